// File: src/crb_pkg.sv
`timescale 1ns / 1ps

package crb_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
	localparam int CP_W      = 21;
	localparam int CLS_W     = 8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the accepted item
		logic insert;     // insert the captured item in sorted position
		logic emit;       // move the head entry to the output register and shift down
		logic emit_last;  // the emitted entry closes the run for this item
	} crb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fill_zero;
		logic fill_one;
		logic fill_full;
		logic pre_flush;  // the offered item forces a flush before its insertion
		logic eot;        // the captured item is marked as end of text
	} crb_stat_t;

endpackage

// File: src/crb_in_if.sv
`timescale 1ns / 1ps

interface crb_in_if;
	logic                      valid;
	logic                      ready;
	logic [crb_pkg::CP_W-1:0]  code_point;
	logic [crb_pkg::CLS_W-1:0] combining_class;
	logic                      end_of_text;

	modport source (output valid, output code_point, output combining_class,
		output end_of_text, input ready);
	modport sink (input valid, input code_point, input combining_class,
		input end_of_text, output ready);
endinterface

// File: src/crb_out_if.sv
`timescale 1ns / 1ps

interface crb_out_if;
	logic                      valid;
	logic                      ready;
	logic [crb_pkg::CP_W-1:0]  out_code_point;
	logic [crb_pkg::CLS_W-1:0] out_class;
	logic                      run_last;

	modport source (output valid, output out_code_point, output out_class,
		output run_last, input ready);
	modport sink (input valid, input out_code_point, input out_class,
		input run_last, output ready);
endinterface

// File: src/crb_datapath.sv
`timescale 1ns / 1ps

module crb_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  crb_pkg::crb_cmd_t         cmd,
	output crb_pkg::crb_stat_t        stat,
	input  logic [crb_pkg::CP_W-1:0]  code_point,
	input  logic [crb_pkg::CLS_W-1:0] combining_class,
	input  logic                      end_of_text,
	output logic [crb_pkg::CP_W-1:0]  out_code_point,
	output logic [crb_pkg::CLS_W-1:0] out_class,
	output logic                      run_last
);

	logic [crb_pkg::CP_W-1:0]   pts_q [crb_pkg::BUF_DEPTH];
	logic [crb_pkg::CLS_W-1:0]  cls_q [crb_pkg::BUF_DEPTH];
	logic [crb_pkg::FILL_W-1:0] fill_q;

	logic [crb_pkg::CP_W-1:0]  item_cp_q;
	logic [crb_pkg::CLS_W-1:0] item_cls_q;
	logic                      item_eot_q;

	logic [crb_pkg::CP_W-1:0]  out_cp_q;
	logic [crb_pkg::CLS_W-1:0] out_cls_q;
	logic                      out_last_q;

	// Entries that must move up one place to make room for the new item.
	// The buffer is sorted, so these form a suffix of the occupied entries.
	logic [crb_pkg::BUF_DEPTH-1:0] gt;

	always_comb begin
		for (int i = 0; i < crb_pkg::BUF_DEPTH; i++) begin
			gt[i] = (crb_pkg::FILL_W'(i) < fill_q) && (cls_q[i] > item_cls_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_cp_q  <= code_point;
			item_cls_q <= combining_class;
			item_eot_q <= end_of_text;
		end
		if (cmd.emit) begin
			out_cp_q   <= pts_q[0];
			out_cls_q  <= cls_q[0];
			out_last_q <= cmd.emit_last;
		end
	end

	for (genvar g = 0; g < crb_pkg::BUF_DEPTH; g++) begin : g_cell
		logic slot_here;
		assign slot_here = gt[g] || (crb_pkg::FILL_W'(g) == fill_q);

		always_ff @(posedge clk) begin
			if (cmd.emit) begin
				if (g < crb_pkg::BUF_DEPTH - 1) begin
					pts_q[g] <= pts_q[(g + 1) % crb_pkg::BUF_DEPTH];
					cls_q[g] <= cls_q[(g + 1) % crb_pkg::BUF_DEPTH];
				end
			end else if (cmd.insert) begin
				if (g > 0 && gt[(g + crb_pkg::BUF_DEPTH - 1) % crb_pkg::BUF_DEPTH]) begin
					pts_q[g] <= pts_q[(g + crb_pkg::BUF_DEPTH - 1) % crb_pkg::BUF_DEPTH];
					cls_q[g] <= cls_q[(g + crb_pkg::BUF_DEPTH - 1) % crb_pkg::BUF_DEPTH];
				end else if (slot_here) begin
					pts_q[g] <= item_cp_q;
					cls_q[g] <= item_cls_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.emit) begin
			fill_q <= fill_q - crb_pkg::FILL_W'(1);
		end else if (cmd.insert) begin
			fill_q <= fill_q + crb_pkg::FILL_W'(1);
		end
	end

	always_comb begin
		stat.fill_zero = (fill_q == '0);
		stat.fill_one  = (fill_q == crb_pkg::FILL_W'(1));
		stat.fill_full = (fill_q == crb_pkg::FILL_W'(crb_pkg::BUF_DEPTH));
		stat.pre_flush = (!stat.fill_zero && combining_class == '0) || stat.fill_full;
		stat.eot       = item_eot_q;
	end

	assign out_code_point = out_cp_q;
	assign out_class      = out_cls_q;
	assign run_last       = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= crb_pkg::FILL_W'(crb_pkg::BUF_DEPTH))
	else $error("fill count beyond buffer depth");

	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> fill_q == $past(fill_q) + crb_pkg::FILL_W'(1))
	else $error("insertion did not grow the buffer by one");

	a_fill_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> fill_q == $past(fill_q) - crb_pkg::FILL_W'(1))
	else $error("emission did not shrink the buffer by one");

endmodule

// File: src/crb_ctrl.sv
`timescale 1ns / 1ps

module crb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  crb_pkg::crb_stat_t  stat,
	output crb_pkg::crb_cmd_t   cmd,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  logic                result_ready
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PRE  = 2'd1;
	localparam logic [1:0] S_INS  = 2'd2;
	localparam logic [1:0] S_POST = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free  = !out_valid_q || result_ready;
	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.insert    = 1'b0;
		cmd.emit      = 1'b0;
		cmd.emit_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.pre_flush ? S_PRE : S_INS;
				end
			end
			S_PRE: begin
				if (slot_free) begin
					cmd.emit      = 1'b1;
					// The run closes here only if no flush follows at end of text.
					cmd.emit_last = stat.fill_one && !stat.eot;
					if (stat.fill_one) begin
						state_d = S_INS;
					end
				end
			end
			S_INS: begin
				cmd.insert = 1'b1;
				state_d    = stat.eot ? S_POST : S_IDLE;
			end
			S_POST: begin
				if (slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = stat.fill_one;
					if (stat.fill_one) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !stat.fill_zero)
	else $error("emission from an empty buffer");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !stat.fill_full)
	else $error("insertion into a full buffer");

	a_post_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST && cmd.emit && cmd.emit_last) |=> state_q == S_IDLE)
	else $error("end of text flush did not return to idle");

endmodule

// File: src/canonical_reorder_buffer.sv
`timescale 1ns / 1ps

// Canonical ordering of decoded code points. Items wait in a 32-entry buffer
// kept stably sorted by combining class; the buffer drains in order when a
// starter arrives while it holds items, when it is full, or after an item
// marked end of text has been inserted, and the last result of each run
// carries run_last. An item that causes no flush is first accepted, then
// placed by a parallel insertion. A flush drains the held entries through
// the single output register, which takes the head entry whenever it is
// empty or the result side takes a transaction. No clearing pass is needed
// after reset.
module canonical_reorder_buffer (
	input logic        clk,
	input logic        arst_n,
	crb_in_if.sink     item,
	crb_out_if.source  result
);

	crb_pkg::crb_cmd_t  cmd;
	crb_pkg::crb_stat_t stat;

	crb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.cmd          (cmd),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready)
	);

	crb_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.code_point      (item.code_point),
		.combining_class (item.combining_class),
		.end_of_text     (item.end_of_text),
		.out_code_point  (result.out_code_point),
		.out_class       (result.out_class),
		.run_last        (result.run_last)
	);

endmodule

// File: verif/canonical_reorder_buffer_tb.sv
`timescale 1ns / 1ps

module canonical_reorder_buffer_tb;

	localparam int RANDOM_ITEMS = 396;

	typedef struct packed {
		logic [crb_pkg::CP_W-1:0]  cp;
		logic [crb_pkg::CLS_W-1:0] cls;
		logic                      last;
	} glyph_t;

	// Keeps its own copy of the sorted buffer and queues the code points that
	// must leave the block, in canonical order.
	class ordering_scoreboard;
		logic [crb_pkg::CP_W-1:0]  held_cp[crb_pkg::BUF_DEPTH];
		logic [crb_pkg::CLS_W-1:0] held_cls[crb_pkg::BUF_DEPTH];
		int unsigned               fill;
		glyph_t                    due_q[$];
		int unsigned               errors;

		function void drain_held();
			glyph_t g;
			for (int i = 0; i < fill; i++) begin
				g.cp   = held_cp[i];
				g.cls  = held_cls[i];
				g.last = 1'b0;
				due_q.push_back(g);
			end
			fill = 0;
		endfunction

		function void note_item(logic [crb_pkg::CP_W-1:0] cp,
			logic [crb_pkg::CLS_W-1:0] cls, logic eot);
			int     queued;
			int     pos;
			glyph_t tail;
			queued = due_q.size();
			if ((fill > 0 && cls == '0) || fill >= crb_pkg::BUF_DEPTH)
				drain_held();
			// Stable insertion: the new entry goes after every entry of equal class.
			pos = fill;
			while (pos > 0 && held_cls[pos-1] > cls) begin
				held_cp[pos]  = held_cp[pos-1];
				held_cls[pos] = held_cls[pos-1];
				pos--;
			end
			held_cp[pos]  = cp;
			held_cls[pos] = cls;
			fill++;
			if (eot)
				drain_held();
			if (due_q.size() > queued) begin
				tail      = due_q.pop_back();
				tail.last = 1'b1;
				due_q.push_back(tail);
			end
		endfunction

		function void check_result(logic [crb_pkg::CP_W-1:0] cp,
			logic [crb_pkg::CLS_W-1:0] cls, logic last);
			glyph_t want;
			if (due_q.size() == 0) begin
				$error("unexpected result: out_code_point %h out_class %0d run_last %0b",
					cp, cls, last);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (cp !== want.cp) begin
				$error("out_code_point mismatch: expected %h, actual %h", want.cp, cp);
				errors++;
			end
			if (cls !== want.cls) begin
				$error("out_class mismatch: expected %0d, actual %0d", want.cls, cls);
				errors++;
			end
			if (last !== want.last) begin
				$error("run_last mismatch: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	crb_in_if  item_if ();
	crb_out_if result_if ();

	canonical_reorder_buffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	ordering_scoreboard sb = new();

	bit src_calm;
	bit snk_calm;
	int unsigned sent;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [crb_pkg::CP_W-1:0] rand_point();
		if ($urandom_range(0, 1) == 0)
			return crb_pkg::CP_W'($urandom_range(0, (1 << crb_pkg::CP_W) - 1));
		return crb_pkg::CP_W'($urandom_range(0, 21'h10FFFF));
	endfunction

	// Mostly classes that occur often in real text, so equal classes meet.
	function automatic logic [crb_pkg::CLS_W-1:0] mark_class();
		case ($urandom_range(0, 7))
			0: return 8'd1;
			1: return 8'd7;
			2: return 8'd202;
			3: return 8'd220;
			4: return 8'd230;
			5: return 8'd232;
			6: return 8'd255;
			default: return crb_pkg::CLS_W'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic send_item(input logic [crb_pkg::CP_W-1:0] cp,
		input logic [crb_pkg::CLS_W-1:0] cls, input logic eot);
		int unsigned gap;
		gap = src_calm ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.valid           <= 1'b1;
		item_if.code_point      <= cp;
		item_if.combining_class <= cls;
		item_if.end_of_text     <= eot;
		do @(posedge clk); while (!item_if.ready);
		sb.note_item(cp, cls, eot);
		sent++;
	endtask

	task automatic send_syllable(input int unsigned marks, input bit noise, input bit close);
		logic [crb_pkg::CLS_W-1:0] cls;
		cls = noise ? crb_pkg::CLS_W'($urandom_range(0, 255)) : '0;
		send_item(rand_point(), cls, close && marks == 0);
		for (int k = 0; k < marks; k++) begin
			cls = noise ? crb_pkg::CLS_W'($urandom_range(0, 255)) : mark_class();
			send_item(rand_point(), cls, close && k == marks - 1);
		end
	endtask

	// Result side: random stalls, then take one transaction and check it.
	initial begin
		int unsigned stall;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = snk_calm ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			sb.check_result(result_if.out_code_point, result_if.out_class,
				result_if.run_last);
		end
	end

	initial begin
		int unsigned seg;
		int unsigned marks;
		bit          close;
		bit          noise;
		arst_n                  = 1'b0;
		item_if.valid           = 1'b0;
		item_if.code_point      = '0;
		item_if.combining_class = '0;
		item_if.end_of_text     = 1'b0;
		src_calm                = 1'b0;
		snk_calm                = 1'b0;
		sent                    = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// End of text into an empty buffer.
		send_item(21'h000041, 8'd0, 1'b1);
		// Starter into an empty buffer, then marks out of order with equal classes.
		send_item(21'h000061, 8'd0, 1'b0);
		send_item(21'h000301, 8'd230, 1'b0);
		send_item(21'h000316, 8'd220, 1'b0);
		send_item(21'h1FFFFF, 8'd255, 1'b0);
		send_item(21'h000000, 8'd1, 1'b0);
		send_item(21'h000327, 8'd220, 1'b0);
		// A starter flushes the held marks.
		send_item(21'h000062, 8'd0, 1'b0);
		send_item(21'h10FFFF, 8'd230, 1'b1);
		// A lone mark with end of text.
		send_item(21'h000300, 8'd230, 1'b1);
		send_item(21'h000000, 8'd0, 1'b0);
		send_item(21'h155555, 8'hAA, 1'b0);
		send_item(21'h0AAAAA, 8'h55, 1'b0);
		// Starter with end of text: a flush before and after its insertion.
		send_item(21'h1FFFFF, 8'd0, 1'b1);

		seg = 0;
		while (sent < 14 + RANDOM_ITEMS) begin
			src_calm = ($urandom_range(0, 4) == 0);
			snk_calm = ($urandom_range(0, 4) == 0);
			close    = ($urandom_range(0, 9) == 0);
			noise    = ($urandom_range(0, 7) == 0);
			if (seg == 0) begin
				// Fills the buffer exactly, so the next starter meets a full buffer.
				marks = crb_pkg::BUF_DEPTH - 1;
				close = 1'b0;
				noise = 1'b0;
			end else if (seg == 1) begin
				// The end-of-text mark arrives on a full buffer: two flushes.
				marks = crb_pkg::BUF_DEPTH;
				close = 1'b1;
				noise = 1'b0;
			end else if ($urandom_range(0, 11) == 0) begin
				marks = $urandom_range(crb_pkg::BUF_DEPTH - 4, crb_pkg::BUF_DEPTH + 8);
			end else begin
				marks = $urandom_range(0, 4);
			end
			send_syllable(marks, noise, close);
			seg++;
		end
		send_item(rand_point(), mark_class(), 1'b1);
		@(negedge clk);
		item_if.valid <= 1'b0;

		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (crb_pkg::BUF_DEPTH + 8) @(posedge clk);
		if (sb.due_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.due_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
src/crb_pkg.sv
src/crb_in_if.sv
src/crb_out_if.sv
src/crb_datapath.sv
src/crb_ctrl.sv
src/canonical_reorder_buffer.sv
verif/canonical_reorder_buffer_tb.sv
